### hdl/sixrm_pkg.sv
`default_nettype none
package sixrm_pkg;

   localparam int unsigned DATA_W    = 64;
   localparam int unsigned IMM_W     = 32;
   localparam int unsigned NUM_INIT  = 6;
   localparam int unsigned PTR_W     = 3;
   localparam int unsigned LEN_W     = 11;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned REQ_W     = 72;
   localparam int unsigned RSP_W     = 200;

   typedef enum logic [3:0] {
      OP_ADDR = 4'd0,
      OP_ADDI = 4'd1,
      OP_MULR = 4'd2,
      OP_MULI = 4'd3,
      OP_BANR = 4'd4,
      OP_BANI = 4'd5,
      OP_BORR = 4'd6,
      OP_BORI = 4'd7,
      OP_SETR = 4'd8,
      OP_SETI = 4'd9,
      OP_GTIR = 4'd10,
      OP_GTRI = 4'd11,
      OP_GTRR = 4'd12,
      OP_EQIR = 4'd13,
      OP_EQRI = 4'd14,
      OP_EQRR = 4'd15
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POINTER_REG = 3'd0,
      CSR_PROGRAM_LEN = 3'd1,
      CSR_INIT_0      = 3'd2,
      CSR_INIT_1      = 3'd3,
      CSR_INIT_2      = 3'd4,
      CSR_INIT_3      = 3'd5,
      CSR_INIT_4      = 3'd6,
      CSR_INIT_5      = 3'd7
   } csr_reg_type;

   // entry 0 in the lowest bits
   localparam logic [NUM_INIT-1:0][DATA_W-1:0] INIT_RESET = {
      64'd10551339, 64'd9, 64'd10551339, 64'd10551339, 64'd0, 64'd16137576
   };

   // first field in the highest bits
   typedef struct packed {
      logic [2:0]       target_index;
      logic [IMM_W-1:0] operand_b;
      logic [IMM_W-1:0] operand_a;
      opcode_type       operation;
      logic             restart;
   } req_item_type;

   typedef struct packed {
      logic [5:0]        pad;
      logic              bad_index;
      logic [DATA_W-1:0] register_zero;
      logic [DATA_W-1:0] written_value;
      logic              halted;
      logic [DATA_W-1:0] next_pointer;
   } rsp_item_type;

endpackage
`default_nettype wire

### hdl/sixrm_mul.sv
`default_nettype none
// 64x64 product, low 64 bits, as registered 32-bit partial products
module sixrm_mul (
   input  wire logic                         clock,
   input  wire logic [sixrm_pkg::DATA_W-1:0] operand_a,
   input  wire logic [sixrm_pkg::DATA_W-1:0] operand_b,
   output logic      [sixrm_pkg::DATA_W-1:0] product
);

   logic [63:0] lo_lo_ff, lo_lo_in;
   logic [31:0] lo_hi_ff, lo_hi_in;
   logic [31:0] hi_lo_ff, hi_lo_in;
   logic [31:0] cross_sum;

   always_comb begin
      lo_lo_in = 64'(operand_a[31:0]) * 64'(operand_b[31:0]);
      lo_hi_in = operand_a[31:0] * operand_b[63:32];
      hi_lo_in = operand_a[63:32] * operand_b[31:0];
   end

   always_ff @(posedge clock) begin
      lo_lo_ff <= lo_lo_in;
      lo_hi_ff <= lo_hi_in;
      hi_lo_ff <= hi_lo_in;
   end

   assign cross_sum = lo_hi_ff + hi_lo_ff;
   assign product   = lo_lo_ff + {cross_sum, 32'd0};

endmodule
`default_nettype wire

### hdl/sixrm_alu.sv
`default_nettype none
module sixrm_alu (
   input  wire sixrm_pkg::opcode_type         operation,
   input  wire logic [sixrm_pkg::DATA_W-1:0] operand_a,
   input  wire logic [sixrm_pkg::DATA_W-1:0] operand_b,
   input  wire logic [sixrm_pkg::DATA_W-1:0] product,
   output logic      [sixrm_pkg::DATA_W-1:0] result
);

   logic greater;
   logic equal;

   assign greater = $signed(operand_a) > $signed(operand_b);
   assign equal   = operand_a == operand_b;

   always_comb begin
      unique case (operation)
         sixrm_pkg::OP_ADDR, sixrm_pkg::OP_ADDI: result = operand_a + operand_b;
         sixrm_pkg::OP_MULR, sixrm_pkg::OP_MULI: result = product;
         sixrm_pkg::OP_BANR, sixrm_pkg::OP_BANI: result = operand_a & operand_b;
         sixrm_pkg::OP_BORR, sixrm_pkg::OP_BORI: result = operand_a | operand_b;
         sixrm_pkg::OP_SETR, sixrm_pkg::OP_SETI: result = operand_a;
         sixrm_pkg::OP_GTIR, sixrm_pkg::OP_GTRI, sixrm_pkg::OP_GTRR:
            result = {63'd0, greater};
         sixrm_pkg::OP_EQIR, sixrm_pkg::OP_EQRI, sixrm_pkg::OP_EQRR:
            result = {63'd0, equal};
      endcase
   end

endmodule
`default_nettype wire

### hdl/six_register_machine_execute_top.sv
// Executes one instruction item per cycle, unless a multiply or a waiting result stalls it,
// on a file of NUM_REGISTERS signed 64-bit registers, one of which (csr register 0) is the
// instruction pointer; each result item carries the pointer after the step, the halt flag,
// the value written, register 0 and the bad-index flag. A restart item loads the six
// initial values. Multiply items wait for the 64-bit product, which is formed from
// registered 32-bit partial products; the next item may follow at once because each one
// only reads the register file left by the one before. An output register holds a result
// that waits on rsp_tready; meanwhile the block takes one more item and then holds
// req_tready low. Configuration must be written while no item is in flight.
`default_nettype none
module six_register_machine_execute_top #(
   parameter int unsigned NUM_REGISTERS = 6,
   parameter int unsigned MAX_PROGRAM   = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // restart, operation, operand_a, operand_b, target_index
   input  wire logic [sixrm_pkg::REQ_W-1:0]     req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // next_pointer, halted, written_value, register_zero, bad_index, zero fill
   output logic      [sixrm_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_wr_en,
   input  wire logic [sixrm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sixrm_pkg::DATA_W-1:0]    csr_wdata
);

   localparam int unsigned IDX_W = $clog2(NUM_REGISTERS);

   typedef logic [NUM_REGISTERS-1:0][sixrm_pkg::DATA_W-1:0] reg_file_type;

   // configuration
   logic [sixrm_pkg::PTR_W-1:0]                            ptr_reg_ff, ptr_reg_in;
   logic [sixrm_pkg::LEN_W-1:0]                            prog_len_ff, prog_len_in;
   logic [sixrm_pkg::NUM_INIT-1:0][sixrm_pkg::DATA_W-1:0] init_ff, init_in;

   // machine state
   reg_file_type regs_ff, regs_in, rst_vals;
   logic         stopped_ff, stopped_in;

   // input and output stages
   sixrm_pkg::req_item_type item_ff, item_in;
   logic                    item_valid_ff, item_valid_in;
   sixrm_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    mul_ready_ff, mul_ready_in;

   logic                          req_accept, out_free, commit;
   logic [31:0]                   ptr_wide, tgt_wide;
   logic                          ptr_ok, tgt_ok, a_ok, b_ok, a_is_reg, b_is_reg, is_mul;
   logic [IDX_W-1:0]              ptr_sel, tgt_idx, a_idx, b_idx;
   logic [sixrm_pkg::DATA_W-1:0]  limit, len_w, max_w, cur_ptr, new_ptr;
   logic [sixrm_pkg::DATA_W-1:0]  a_val, b_val, product, alu_result;
   logic                          exec_path, exec_ok, mul_wait;
   sixrm_pkg::opcode_type         op;

   // configuration writes
   always_comb begin
      ptr_reg_in  = ptr_reg_ff;
      prog_len_in = prog_len_ff;
      init_in     = init_ff;
      if (csr_wr_en) begin
         unique case (sixrm_pkg::csr_reg_type'(csr_index))
            sixrm_pkg::CSR_POINTER_REG: ptr_reg_in  = csr_wdata[sixrm_pkg::PTR_W-1:0];
            sixrm_pkg::CSR_PROGRAM_LEN: prog_len_in = csr_wdata[sixrm_pkg::LEN_W-1:0];
            sixrm_pkg::CSR_INIT_0:      init_in[0]  = csr_wdata;
            sixrm_pkg::CSR_INIT_1:      init_in[1]  = csr_wdata;
            sixrm_pkg::CSR_INIT_2:      init_in[2]  = csr_wdata;
            sixrm_pkg::CSR_INIT_3:      init_in[3]  = csr_wdata;
            sixrm_pkg::CSR_INIT_4:      init_in[4]  = csr_wdata;
            sixrm_pkg::CSR_INIT_5:      init_in[5]  = csr_wdata;
         endcase
      end
   end

   // restart image of the register file
   for (genvar gi = 0; gi < NUM_REGISTERS; gi++) begin : g_rst
      if (gi < sixrm_pkg::NUM_INIT) begin : g_init
         assign rst_vals[gi] = init_ff[gi];
      end else begin : g_zero
         assign rst_vals[gi] = '0;
      end
   end

   // decode
   assign op       = item_ff.operation;
   assign ptr_wide = 32'(ptr_reg_ff);
   assign ptr_ok   = ptr_wide < 32'(NUM_REGISTERS);
   assign ptr_sel  = ptr_ok ? ptr_wide[IDX_W-1:0] : '0;
   assign tgt_wide = 32'(item_ff.target_index);
   assign tgt_ok   = tgt_wide < 32'(NUM_REGISTERS);
   assign tgt_idx  = tgt_ok ? tgt_wide[IDX_W-1:0] : '0;

   assign len_w   = 64'(prog_len_ff);
   assign max_w   = 64'(MAX_PROGRAM);
   assign limit   = (len_w > max_w) ? max_w : len_w;
   assign cur_ptr = regs_ff[ptr_sel];

   always_comb begin
      unique case (op)
         sixrm_pkg::OP_SETI, sixrm_pkg::OP_GTIR, sixrm_pkg::OP_EQIR: a_is_reg = 1'b0;
         default:                                                    a_is_reg = 1'b1;
      endcase
      unique case (op)
         sixrm_pkg::OP_ADDR, sixrm_pkg::OP_MULR, sixrm_pkg::OP_BANR, sixrm_pkg::OP_BORR,
         sixrm_pkg::OP_GTIR, sixrm_pkg::OP_GTRR, sixrm_pkg::OP_EQIR, sixrm_pkg::OP_EQRR:
            b_is_reg = 1'b1;
         default:
            b_is_reg = 1'b0;
      endcase
   end

   // a negative index reads as huge and fails the compare
   assign a_ok  = item_ff.operand_a < 32'(NUM_REGISTERS);
   assign b_ok  = item_ff.operand_b < 32'(NUM_REGISTERS);
   assign a_idx = a_ok ? item_ff.operand_a[IDX_W-1:0] : '0;
   assign b_idx = b_ok ? item_ff.operand_b[IDX_W-1:0] : '0;
   assign a_val = a_is_reg ? regs_ff[a_idx]
                           : {{32{item_ff.operand_a[31]}}, item_ff.operand_a};
   assign b_val = b_is_reg ? regs_ff[b_idx]
                           : {{32{item_ff.operand_b[31]}}, item_ff.operand_b};

   assign exec_path = !item_ff.restart && ptr_ok && !stopped_ff && (cur_ptr < limit);
   assign exec_ok   = exec_path && (a_ok || !a_is_reg) && (b_ok || !b_is_reg) && tgt_ok;
   assign is_mul    = (op == sixrm_pkg::OP_MULR) || (op == sixrm_pkg::OP_MULI);
   assign mul_wait  = exec_ok && is_mul && !mul_ready_ff;

   sixrm_mul u_mul (
      .clock     (clock),
      .operand_a (a_val),
      .operand_b (b_val),
      .product   (product)
   );

   sixrm_alu u_alu (
      .operation (op),
      .operand_a (a_val),
      .operand_b (b_val),
      .product   (product),
      .result    (alu_result)
   );

   assign new_ptr = ((tgt_idx == ptr_sel) ? alu_result : cur_ptr) + 64'd1;

   // handshakes
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = item_valid_ff && out_free && !mul_wait;
   assign req_tready = !item_valid_ff || commit;
   assign req_accept = req_tvalid && req_tready;

   assign item_valid_in = req_accept || (item_valid_ff && !commit);
   assign item_in       = req_accept ? sixrm_pkg::req_item_type'(req_tdata) : item_ff;
   assign mul_ready_in  = item_valid_ff && !commit;
   assign rsp_valid_in  = commit || (rsp_valid_ff && !rsp_tready);

   // state update
   always_comb begin
      regs_in    = regs_ff;
      stopped_in = stopped_ff;
      if (commit) begin
         priority if (item_ff.restart) begin
            regs_in    = rst_vals;
            stopped_in = !ptr_ok || !(rst_vals[ptr_sel] < limit);
         end else if (!ptr_ok || !exec_path) begin
            stopped_in = 1'b1;
         end else if (exec_ok) begin
            regs_in[tgt_idx] = alu_result;
            regs_in[ptr_sel] = new_ptr;
            stopped_in       = !(new_ptr < limit);
         end else begin
            stopped_in = stopped_ff;
         end
      end
   end

   always_comb begin
      rsp_item_in               = rsp_item_ff;
      if (commit) begin
         rsp_item_in.pad           = '0;
         rsp_item_in.next_pointer  = ptr_ok ? regs_in[ptr_sel] : '0;
         rsp_item_in.halted        = ptr_ok ? stopped_in : 1'b1;
         rsp_item_in.written_value = exec_ok ? alu_result : '0;
         rsp_item_in.register_zero = regs_in[0];
         rsp_item_in.bad_index     = item_ff.restart ? !ptr_ok
                                                     : (!ptr_ok || (exec_path && !exec_ok));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_reg_ff    <= '0;
         prog_len_ff   <= '0;
         init_ff       <= sixrm_pkg::INIT_RESET;
         regs_ff       <= '0;
         stopped_ff    <= 1'b0;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mul_ready_ff  <= 1'b0;
      end else begin
         ptr_reg_ff    <= ptr_reg_in;
         prog_len_ff   <= prog_len_in;
         init_ff       <= init_in;
         regs_ff       <= regs_in;
         stopped_ff    <= stopped_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         mul_ready_ff  <= mul_ready_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tvalid = rsp_valid_ff;

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed item has no result");

   a_bad_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.bad_index) |-> (rsp_item_ff.written_value == '0))
      else $error("bad index result reports a write");

   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      (commit && !item_ff.restart && stopped_ff) |=> (regs_ff == $past(regs_ff)))
      else $error("halted machine changed its registers");

   a_ptr_report: assert property (@(posedge clock) disable iff (reset)
      (commit && exec_ok) |=> (rsp_item_ff.next_pointer == regs_ff[$past(ptr_sel)]))
      else $error("reported pointer differs from pointer register");

endmodule
`default_nettype wire
